/* rtl/bvir_pkg.sv */
// shared types and constants for the bounded vector insert/remove core
// request and status codes, cell command word, read tree depth helper
// no dependencies
package bvir_pkg;

  localparam int POS_W  = 9;
  localparam int CFG_W  = 9;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 2;
  localparam int APB_DW = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

  localparam int TREE_FAN = 16;

  typedef enum logic [1:0] {
    C_HOLD,
    C_WRITE,
    C_INSERT,
    C_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

  // registered levels of the fan-in 16 read tree
  function automatic int tree_levels(input int depth);
    int lv;
    if (depth <= 16) begin
      lv = 1;
    end else if (depth <= 256) begin
      lv = 2;
    end else begin
      lv = 3;
    end
    return lv;
  endfunction

endpackage

/* rtl/bvir_cell.sv */
// one storage cell of the list: holds one entry and shifts with its neighbors
// uses bvir_pkg for the cell command word
module bvir_cell
  import bvir_pkg::*;
#(
  parameter int IDX = 0,
  parameter int W   = 32
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [W-1:0]     value_i,
  input  logic [W-1:0]     left_i,
  input  logic [W-1:0]     right_i,
  input  logic [POS_W-1:0] rd_pos_i,
  output logic [W-1:0]     data_o,
  output logic [W-1:0]     rd_o
);

  logic [W-1:0] data_q, data_d;
  logic         at_pos, past_pos;

  assign at_pos   = 32'(cmd_i.pos) == 32'(IDX);
  assign past_pos = 32'(cmd_i.pos) <  32'(IDX);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      C_HOLD: begin
        data_d = data_q;
      end
      C_WRITE: begin
        if (at_pos) data_d = value_i;
      end
      C_INSERT: begin
        // later entries move up, the new one lands at the position
        if (past_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = value_i;
        end
      end
      C_REMOVE: begin
        if (at_pos || past_pos) data_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (32'(rd_pos_i) == 32'(IDX)) ? data_q : '0;

endmodule

/* rtl/bvir_or_tree.sv */
// registered or-reduction tree that collects the selected cell word
// uses bvir_pkg for fan-in and level count
module bvir_or_tree
  import bvir_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int W     = 32
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [DEPTH],
  output logic [W-1:0] root_o
);

  localparam int LEVELS = tree_levels(DEPTH);
  localparam int PAD    = 1 << (4 * LEVELS);
  localparam int NODES0 = PAD / TREE_FAN;

  logic [W-1:0] node_q [LEVELS][NODES0];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int N = PAD >> (4 * (l + 1));
    for (genvar k = 0; k < N; k++) begin : g_node
      logic [W-1:0] kid [TREE_FAN];
      logic [W-1:0] sum;
      for (genvar j = 0; j < TREE_FAN; j++) begin : g_kid
        if (l == 0) begin : g_leaf
          if (k * TREE_FAN + j < DEPTH) begin : g_real
            assign kid[j] = leaf_i[k*TREE_FAN+j];
          end else begin : g_pad
            assign kid[j] = '0;
          end
        end else begin : g_inner
          assign kid[j] = node_q[l-1][k*TREE_FAN+j];
        end
      end
      always_comb begin
        sum = '0;
        for (int j = 0; j < TREE_FAN; j++) begin
          sum = sum | kid[j];
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[l][k] <= sum;
      end
    end
  end

  assign root_o = node_q[LEVELS-1][0];

endmodule

/* rtl/bounded_vector_insert_remove_core.sv */
// Bounded ordered list with push, pop, insert, remove, get, set and clear.
// Input channel (in_valid_i/in_ready_o) takes one request word: action_i,
// position_i, item_value_i. Output channel (out_valid_o/out_ready_i) returns
// one result word per request: status_o, read_value_o, length_now_o and
// is_empty_o, in request order.
// Entries sit in a row of cells; insert and remove shift every later cell by
// one in the cycle the request is accepted. A get is answered through a
// registered or-tree of fan-in 16 over the cells, L levels deep (L = 1 for
// DEPTH <= 16, 2 for DEPTH <= 256, else 3); every request waits out those
// levels before its result is queued, and one request is in flight at a
// time: a new request is taken only once the last result is queued.
// Results go into a two-word output queue, so a request is still taken
// while one finished result waits; with two results waiting in_ready_o
// drops until the receiver takes one.
// Reset empties the list and queue, sets capacity_in_use (APB address 0) to
// 256. Change capacity_in_use only while idle; it is not enforced.
module bounded_vector_insert_remove_core
  import bvir_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [ITEM_WIDTH-1:0] item_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ST_W-1:0]       status_o,
  output logic [ITEM_WIDTH-1:0] read_value_o,
  output logic [POS_W-1:0]      length_now_o,
  output logic                  is_empty_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int W      = ITEM_WIDTH;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int MW     = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(DEPTH);
  localparam int CNT_W  = $clog2(LEVELS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  // configuration
  logic [CFG_W-1:0] cap_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == ADDR_CAPACITY);
  assign prdata = APB_DW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we) begin
      cap_q <= pwdata[CFG_W-1:0];
    end
  end

  // request decode
  logic              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [CW-1:0]     count_q, count_d;
  logic [ST_W-1:0]   job_status_q, status_d;
  logic              job_get_q, get_d;
  logic [POS_W-1:0]  rd_pos_q;
  logic [1:0]        fcnt_q;
  logic              in_fire, out_fire, done;
  logic [MW-1:0]     cap_eff, cnt_m, pos_m;
  logic              full, empty_now;
  cell_cmd_t         cmd;

  assign in_ready_o = (state_q == S_IDLE) && (fcnt_q != 2'd2);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_o & out_ready_i;
  assign done       = (state_q == S_BUSY) && (cnt_q == CNT_W'(LEVELS));

  assign cap_eff   = (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);
  assign cnt_m     = MW'(count_q);
  assign pos_m     = MW'(position_i);
  assign full      = cnt_m >= cap_eff;
  assign empty_now = count_q == '0;

  always_comb begin
    status_d = ST_OK;
    get_d    = 1'b0;
    count_d  = count_q;
    cmd.op   = C_HOLD;
    cmd.pos  = position_i;
    unique case (action_i)
      ACT_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = C_WRITE;
          cmd.pos = POS_W'(count_q);
          count_d = count_q + 1'b1;
        end
      end
      ACT_POP: begin
        if (empty_now) status_d = ST_EMPTY;
        else count_d = count_q - 1'b1;
      end
      ACT_INSERT: begin
        priority if (pos_m > cnt_m) begin
          status_d = ST_BAD_INDEX;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = C_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      ACT_REMOVE: begin
        priority if (empty_now) begin
          status_d = ST_EMPTY;
        end else if (pos_m >= cnt_m) begin
          status_d = ST_BAD_INDEX;
        end else begin
          cmd.op  = C_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
      ACT_GET: begin
        priority if (empty_now) status_d = ST_EMPTY;
        else if (pos_m >= cnt_m) status_d = ST_BAD_INDEX;
        else get_d = 1'b1;
      end
      ACT_SET: begin
        priority if (empty_now) begin
          status_d = ST_EMPTY;
        end else if (pos_m >= cnt_m) begin
          status_d = ST_BAD_INDEX;
        end else begin
          cmd.op = C_WRITE;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    // cells only move on an accepted request
    if (!in_fire) cmd.op = C_HOLD;
  end

  always_comb begin
    state_d = state_q;
    if (in_fire) state_d = S_BUSY;
    else if (done) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q   <= '0;
        count_q <= count_d;
      end else if (state_q == S_BUSY && !done) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_status_q <= status_d;
      job_get_q    <= get_d;
      rd_pos_q     <= position_i;
    end
  end

  // cell row
  logic [W-1:0] cell_data [DEPTH];
  logic [W-1:0] cell_rd   [DEPTH];
  logic [W-1:0] tree_root;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    bvir_cell #(
      .IDX (i),
      .W   (W)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .value_i  (item_value_i),
      .left_i   (left_w),
      .right_i  (right_w),
      .rd_pos_i (rd_pos_q),
      .data_o   (cell_data[i]),
      .rd_o     (cell_rd[i])
    );
  end

  bvir_or_tree #(
    .DEPTH (DEPTH),
    .W     (W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_rd),
    .root_o (tree_root)
  );

  // two-word result queue
  logic [ST_W-1:0]  q_st_q  [2];
  logic [W-1:0]     q_rv_q  [2];
  logic [POS_W-1:0] q_len_q [2];
  logic             q_emp_q [2];
  logic             wr_ptr_q, rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fcnt_q   <= '0;
    end else begin
      if (done) wr_ptr_q <= ~wr_ptr_q;
      if (out_fire) rd_ptr_q <= ~rd_ptr_q;
      if (done && !out_fire) fcnt_q <= fcnt_q + 1'b1;
      else if (!done && out_fire) fcnt_q <= fcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      q_st_q[wr_ptr_q]  <= job_status_q;
      q_rv_q[wr_ptr_q]  <= job_get_q ? tree_root : '0;
      q_len_q[wr_ptr_q] <= POS_W'(count_q);
      q_emp_q[wr_ptr_q] <= count_q == '0;
    end
  end

  assign out_valid_o  = fcnt_q != '0;
  assign status_o     = q_st_q[rd_ptr_q];
  assign read_value_o = q_rv_q[rd_ptr_q];
  assign length_now_o = q_len_q[rd_ptr_q];
  assign is_empty_o   = q_emp_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count beyond depth");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q != 2'd3)
    else $error("result queue overflow");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_BUSY) && !in_ready_o)
    else $error("request accepted while one is in flight");

  a_done_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (fcnt_q != 2'd2) || out_fire)
    else $error("result written into a full queue");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_value_o == '0)
    else $error("failed request returned data");
`endif

endmodule
